// ===== hw/rtl/ptsw_pkg.sv =====
// shared constants, operation codes and control structs for the scheduler
// no dependencies
`default_nettype none
package ptsw_pkg;

  localparam int NUM_PRIO = 8;
  localparam int PRIO_W   = $clog2(NUM_PRIO);
  localparam int LVL_W    = PRIO_W + 1;
  localparam int DEPTH_W  = $clog2(NUM_PRIO + 1);
  localparam int TICK_W   = 16;
  localparam int LIMIT_W  = 4;
  localparam int OP_W     = 3;
  localparam int DLY_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [OP_W-1:0] OP_CREATE = 3'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd1;
  localparam logic [OP_W-1:0] OP_DELAY  = 3'd2;
  localparam logic [OP_W-1:0] OP_RESUME = 3'd3;
  localparam logic [OP_W-1:0] OP_SCHED  = 3'd4;
  localparam logic [OP_W-1:0] OP_FINISH = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_PREEMPT_ON = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT      = 1'd1;

  localparam logic [PRIO_W-1:0] LAST_PRIO = PRIO_W'(NUM_PRIO - 1);
  localparam logic signed [LVL_W-1:0] NO_TASK = '1;

  // sequencer to datapath
  typedef struct packed {
    logic              accept;
    logic              exec;
    logic              rd_en;
    logic              cmp_vld;
    logic [PRIO_W-1:0] cmp_idx;
    logic              sched_step;
    logic [PRIO_W-1:0] idx;
    logic              emit;
  } ptsw_ctrl_t;

  // datapath to sequencer
  typedef struct packed {
    logic sched_stop;
    logic out_free;
  } ptsw_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/priority_task_scheduler_with_wakeup_core.sv =====
// fixed-priority scheduler: create/resume/delay/finish execute in S_EXEC after accept,
// tick: S_TICK (one wake tick entry compared per cycle via the ram read port), then S_TWAIT,
// schedule: S_SCHED (one level scanned per cycle from the top down); all end in S_EMIT.
// one word in flight; the next word is taken the cycle after its result is registered.
// reset: no task ready or blocked, tick 0, nothing running, stack empty, preemption on,
// no preemption limit; wake ticks and stack entries are only read once written
`default_nettype none
module priority_task_scheduler_with_wakeup_core
  import ptsw_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic [OP_W-1:0]       op_i,
  input  wire logic [PRIO_W-1:0]     task_priority_i,
  input  wire logic [DLY_W-1:0]      delay_ticks_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic                  chosen_valid_o,
  output      logic [PRIO_W-1:0]     chosen_priority_o,
  output      logic                  preempt_pending_o,
  output      logic signed [LVL_W-1:0] current_level_o,
  output      logic [TICK_W-1:0]     tick_now_o,
  output      logic [NUM_PRIO-1:0]   ready_mask_o,
  output      logic                  op_error_o
);

  ptsw_ctrl_t ctrl;
  ptsw_stat_t stat;

  logic [NUM_PRIO-1:0]     ready_q, blocked_q;
  logic [TICK_W-1:0]       tick_q;
  logic signed [LVL_W-1:0] run_q;
  logic [LVL_W-1:0]        stack_q [NUM_PRIO];
  logic [DEPTH_W-1:0]      depth_q;
  logic                    flag_q;
  logic                    pre_on_q;
  logic [LIMIT_W-1:0]      limit_q;
  logic [OP_W-1:0]         op_q;
  logic [PRIO_W-1:0]       tp_q;
  logic [DLY_W-1:0]        dly_q;
  logic                    cv_q, err_q;
  logic [PRIO_W-1:0]       cp_q;
  logic                    out_valid_q;

  logic [TICK_W-1:0]       rdata;
  logic                    ram_we;
  logic [TICK_W-1:0]       wake_at;
  logic                    tp_ok;
  logic                    idle_run;
  logic                    wake_hit;
  logic                    sched_gt;
  logic                    sched_ok;
  logic [DEPTH_W-1:0]      depth_m1;

  // a level that has just become ready may raise preempt pending
  function automatic logic wake_ok(input logic [PRIO_W-1:0] p, input logic pre_on,
                                   input logic [LIMIT_W-1:0] limit,
                                   input logic signed [LVL_W-1:0] run);
    logic r;
    r = pre_on;
    if (limit != '0 && LIMIT_W'(p) < limit) begin
      r = 1'b0;
    end
    if (!(run[LVL_W-1] || $signed({1'b0, p}) > run)) begin
      r = 1'b0;
    end
    return r;
  endfunction

  ptsw_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  assign idle_run = run_q[LVL_W-1];
  assign tp_ok    = (32'(tp_q) < NUM_PRIO);
  assign wake_at  = tick_q + dly_q;
  assign ram_we   = ctrl.exec & (op_q == OP_DELAY) & !idle_run & (dly_q != '0);
  assign depth_m1 = depth_q - 1'b1;

  ptsw_tick_ram u_tick_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (run_q[PRIO_W-1:0]),
    .wdata_i (wake_at),
    .re_i    (ctrl.rd_en),
    .raddr_i (ctrl.idx),
    .rdata_o (rdata)
  );

  // compare logic: wake tick match during tick, level compare during schedule
  assign wake_hit = blocked_q[ctrl.cmp_idx] & (rdata == tick_q);
  assign sched_gt = $signed({1'b0, ctrl.idx}) > run_q;
  assign sched_ok = !(pre_on_q && limit_q != '0 && !idle_run &&
                      LIMIT_W'(ctrl.idx) < limit_q) &&
                    (32'(depth_q) < NUM_PRIO);

  always_comb begin
    stat.sched_stop = !sched_gt | ready_q[ctrl.idx] | (ctrl.idx == '0);
    stat.out_free   = !out_valid_q | out_ready_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_on_q <= 1'b1;
      limit_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PREEMPT_ON: pre_on_q <= cfg_data_i[0];
        CFG_LIMIT:      limit_q  <= cfg_data_i[LIMIT_W-1:0];
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      op_q  <= op_i;
      tp_q  <= task_priority_i;
      dly_q <= delay_ticks_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.sched_step && sched_gt && ready_q[ctrl.idx] && sched_ok) begin
      stack_q[depth_q[PRIO_W-1:0]] <= run_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q   <= '0;
      blocked_q <= '0;
      tick_q    <= '0;
      run_q     <= NO_TASK;
      depth_q   <= '0;
      flag_q    <= 1'b0;
      cv_q      <= 1'b0;
      cp_q      <= '0;
      err_q     <= 1'b0;
    end else begin
      if (ctrl.accept) begin
        cv_q  <= 1'b0;
        cp_q  <= '0;
        err_q <= 1'b0;
        if (op_i == OP_TICK) begin
          tick_q <= tick_q + 1'b1;
        end
        if (op_i == OP_SCHED) begin
          flag_q <= 1'b0;
        end
      end
      if (ctrl.cmp_vld && wake_hit) begin
        ready_q[ctrl.cmp_idx]   <= 1'b1;
        blocked_q[ctrl.cmp_idx] <= 1'b0;
        if (wake_ok(ctrl.cmp_idx, pre_on_q, limit_q, run_q)) begin
          flag_q <= 1'b1;
        end
      end
      if (ctrl.sched_step && sched_gt && ready_q[ctrl.idx] && sched_ok) begin
        depth_q <= depth_q + 1'b1;
        run_q   <= $signed({1'b0, ctrl.idx});
        cv_q    <= 1'b1;
        cp_q    <= ctrl.idx;
      end
      if (ctrl.exec) begin
        case (op_q)
          OP_CREATE: begin
            if (tp_ok) begin
              ready_q[tp_q]   <= 1'b1;
              blocked_q[tp_q] <= 1'b0;
            end
          end
          OP_RESUME: begin
            if (tp_ok) begin
              ready_q[tp_q]   <= 1'b1;
              blocked_q[tp_q] <= 1'b0;
              if (wake_ok(tp_q, pre_on_q, limit_q, run_q)) begin
                flag_q <= 1'b1;
              end
            end
          end
          OP_DELAY: begin
            if (idle_run) begin
              err_q <= 1'b1;
            end else if (dly_q != '0) begin
              ready_q[run_q[PRIO_W-1:0]]   <= 1'b0;
              blocked_q[run_q[PRIO_W-1:0]] <= 1'b1;
            end
          end
          OP_FINISH: begin
            if (idle_run) begin
              err_q <= 1'b1;
            end else if (depth_q == '0) begin
              run_q <= NO_TASK;
            end else begin
              depth_q <= depth_m1;
              run_q   <= $signed(stack_q[depth_m1[PRIO_W-1:0]]);
            end
          end
          default: ;
        endcase
      end
    end
  end

  // result register, loaded once the word's work is complete
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      chosen_valid_o    <= cv_q;
      chosen_priority_o <= cp_q;
      preempt_pending_o <= flag_q;
      current_level_o   <= run_q;
      tick_now_o        <= tick_q;
      ready_mask_o      <= ready_q;
      op_error_o        <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ptsw_tick_ram.sv =====
// wake tick store, one entry per priority level, registered read
// depends on ptsw_pkg
`default_nettype none
module ptsw_tick_ram
  import ptsw_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [PRIO_W-1:0] waddr_i,
  input  wire logic [TICK_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [PRIO_W-1:0] raddr_i,
  output      logic [TICK_W-1:0] rdata_o
);

  logic [TICK_W-1:0] mem [NUM_PRIO];
  logic [TICK_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/ptsw_seq.sv =====
// sequencer: walks the priority levels one per cycle for tick and schedule
// depends on ptsw_pkg
`default_nettype none
module ptsw_seq
  import ptsw_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic [OP_W-1:0] op_i,
  output      logic            in_ready_o,
  input  wire ptsw_stat_t      stat_i,
  output      ptsw_ctrl_t      ctrl_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_TICK  = 3'd2;
  localparam logic [2:0] S_TWAIT = 3'd3;
  localparam logic [2:0] S_SCHED = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [PRIO_W-1:0] idx_q, idx_d;
  logic              cmp_vld_q;
  logic [PRIO_W-1:0] cmp_idx_q;
  logic              accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_i)
            OP_TICK: begin
              state_d = S_TICK;
              idx_d   = '0;
            end
            OP_SCHED: begin
              state_d = S_SCHED;
              idx_d   = LAST_PRIO;
            end
            default: state_d = S_EXEC;
          endcase
        end
      end
      S_EXEC: state_d = S_EMIT;
      S_TICK: begin
        idx_d = idx_q + 1'b1;
        if (idx_q == LAST_PRIO) begin
          state_d = S_TWAIT;
        end
      end
      S_TWAIT: state_d = S_EMIT;
      S_SCHED: begin
        if (stat_i.sched_stop) begin
          state_d = S_EMIT;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      cmp_vld_q <= 1'b0;
      cmp_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      // compare runs in the cycle after the read issue
      cmp_vld_q <= (state_q == S_TICK);
      cmp_idx_q <= idx_q;
    end
  end

  always_comb begin
    ctrl_o.accept     = accept;
    ctrl_o.exec       = (state_q == S_EXEC);
    ctrl_o.rd_en      = (state_q == S_TICK);
    ctrl_o.cmp_vld    = cmp_vld_q;
    ctrl_o.cmp_idx    = cmp_idx_q;
    ctrl_o.sched_step = (state_q == S_SCHED);
    ctrl_o.idx        = idx_q;
    ctrl_o.emit       = (state_q == S_EMIT) & stat_i.out_free;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ptsw_checker.sv =====
// port-level checks for the scheduler top level, attached by bind
// depends on ptsw_pkg
`default_nettype none
module ptsw_checker
  import ptsw_pkg::*;
(
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    out_valid_o,
  input wire logic                    out_ready_i,
  input wire logic                    chosen_valid_o,
  input wire logic [PRIO_W-1:0]       chosen_priority_o,
  input wire logic signed [LVL_W-1:0] current_level_o,
  input wire logic                    op_error_o,
  input wire logic                    in_valid_i,
  input wire logic                    in_ready_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // a selected task is the running level
  a_chosen_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && chosen_valid_o |-> current_level_o == $signed({1'b0, chosen_priority_o}))
    else $error("chosen level is not the running level");

  // the only negative level is no task
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && current_level_o[LVL_W-1] |-> current_level_o == NO_TASK)
    else $error("running level out of range");

  // an ignored operation selects nothing
  a_err_no_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && op_error_o |-> !chosen_valid_o)
    else $error("error and selection together");

  // no second word is taken in the cycle after a word is accepted
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word taken while busy");

endmodule

bind priority_task_scheduler_with_wakeup_core ptsw_checker u_ptsw_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .chosen_valid_o    (chosen_valid_o),
  .chosen_priority_o (chosen_priority_o),
  .current_level_o   (current_level_o),
  .op_error_o        (op_error_o),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o)
);
`default_nettype wire
